// ===== src/cpto_pkg.sv =====
// ----------------------------------------------------------------------------
// cpto_pkg
// Shared types and constants of the core predictor and clock offset block.
// ----------------------------------------------------------------------------
package cpto_pkg;

	localparam int IN_W     = 144;
	localparam int OUT_W    = 72;
	localparam int CFG_AW   = 4;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = 2;
	localparam int Q_LVL_W  = 3;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [19:0] NS_PER_MS  = 20'd1000000;
	localparam logic [31:0] RNG_RESET  = 32'd2596069104;

	localparam logic [23:0] MISPREDICT_RESET = 24'd54780;
	localparam logic [23:0] HIT_RESET        = 24'd27435;
	localparam logic [23:0] PASSIVE_RESET    = 24'd100000;

	typedef enum logic [1:0] {
		POL_RECENT = 2'd0,
		POL_RANDOM = 2'd1,
		POL_FREQ   = 2'd2,
		POL_WINDOW = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		REG_POLICY     = 2'd0,
		REG_MISPREDICT = 2'd1,
		REG_HIT        = 2'd2,
		REG_PASSIVE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		policy_t     policy;
		logic [23:0] mispredict_penalty_ns;
		logic [23:0] hit_overhead_ns;
		logic [23:0] passive_error_ns;
	} cfg_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage

// ===== src/cpto_front.sv =====
// ----------------------------------------------------------------------------
// cpto_front
// Input stage: unpacks a beat, clamps the core id and forms the clock
// difference without the latency penalty over two pipeline stages.
// ----------------------------------------------------------------------------
module cpto_front import cpto_pkg::*; #(
	parameter int CORES = 4,
	localparam int CW = $clog2(CORES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// phc_ns [63:0], secure_seconds [95:64], secure_millis [105:96],
	// core_id [137:106], zero fill [143:138]
	input  logic [IN_W-1:0]      s_axis_tdata,
	input  logic [Q_LVL_W-1:0]   q_level,
	output logic                 q_push,
	output logic [63:0]          q_tmp,
	output logic [CW-1:0]        q_core
);

	logic [63:0]   phc;
	logic [31:0]   secs;
	logic [9:0]    millis;
	logic [31:0]   core_id;
	logic [CW-1:0] core_clamped;
	logic          accept;

	logic          v_s1;
	logic [63:0]   phc_s1;
	logic [61:0]   sec_ns_s1;
	logic [29:0]   ms_ns_s1;
	logic [CW-1:0] core_s1;

	logic          v_s2;
	logic [63:0]   tmp_s2;
	logic [CW-1:0] core_s2;

	assign phc     = s_axis_tdata[63:0];
	assign secs    = s_axis_tdata[95:64];
	assign millis  = s_axis_tdata[105:96];
	assign core_id = s_axis_tdata[137:106];

	always_comb begin
		if (core_id[31]) begin
			core_clamped = '0;
		end else if (core_id[30:0] >= 31'(CORES)) begin
			core_clamped = CW'(CORES - 1);
		end else begin
			core_clamped = core_id[CW-1:0];
		end
	end

	// Items in the two stages hold a queue slot in advance, so a push always finds room.
	assign s_axis_tready = (Q_LVL_W'(q_level) + Q_LVL_W'(v_s1) + Q_LVL_W'(v_s2))
		< Q_LVL_W'(Q_DEPTH);
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		phc_s1    <= phc;
		sec_ns_s1 <= 62'(secs * NS_PER_SEC);
		ms_ns_s1  <= 30'(millis * NS_PER_MS);
		core_s1   <= core_clamped;
		tmp_s2    <= phc_s1 - 64'(sec_ns_s1) - 64'(ms_ns_s1) - 64'(cfg.passive_error_ns);
		core_s2   <= core_s1;
	end

	assign q_push = v_s2;
	assign q_tmp  = tmp_s2;
	assign q_core = core_s2;

endmodule

// ===== src/cpto_queue.sv =====
// ----------------------------------------------------------------------------
// cpto_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module cpto_queue import cpto_pkg::*; #(
	parameter int CORES = 4,
	localparam int CW = $clog2(CORES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [63:0]        push_tmp,
	input  logic [CW-1:0]      push_core,
	input  logic               pop,
	output logic               pop_valid,
	output logic [63:0]        pop_tmp,
	output logic [CW-1:0]      pop_core,
	output logic [Q_LVL_W-1:0] level
);

	logic [63:0]        tmp_q  [Q_DEPTH];
	logic [CW-1:0]      core_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_LVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tmp_q[wr_ptr_q]  <= push_tmp;
			core_q[wr_ptr_q] <= push_core;
		end
	end

	assign pop_valid = level_q != '0;
	assign pop_tmp   = tmp_q[rd_ptr_q];
	assign pop_core  = core_q[rd_ptr_q];
	assign level     = level_q;

endmodule

// ===== src/cpto_back.sv =====
// ----------------------------------------------------------------------------
// cpto_back
// Back end: predicts the core under the active policy, updates that policy's
// state, and adds the hit or mispredict penalty into the output register.
// ----------------------------------------------------------------------------
module cpto_back import cpto_pkg::*; #(
	parameter int CORES  = 4,
	parameter int WINDOW = 32,
	localparam int CW = $clog2(CORES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_valid,
	input  logic [63:0]      q_tmp,
	input  logic [CW-1:0]    q_core,
	output logic             q_pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// offset_ns [63:0], guessed_core [65:64], missed [66], zero fill [71:67]
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int LEAVES  = 1 << CW;
	localparam int NODES   = 2 * LEAVES - 1;
	localparam int HW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW      = $clog2(WINDOW + 1);
	localparam bit POW2    = (CORES & (CORES - 1)) == 0;

	logic          last_valid_q;
	logic [CW-1:0] last_core_q;
	logic [31:0]   rng_q;
	logic [31:0]   use_cnt_q   [CORES];
	logic [FW-1:0] trace_cnt_q [CORES];
	logic [HW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] ring_mem    [WINDOW];
	logic [CW-1:0] ring_old_q;

	logic [31:0]   rng_next;
	logic [CW-1:0] rng_guess;
	logic [31:0]   node_val [NODES];
	logic [CW-1:0] node_idx [NODES];
	logic [CW-1:0] guess;
	logic          miss;
	logic          full;
	logic          push;
	logic [HW-1:0] head_d;
	logic [31:0]   use_cnt_d   [CORES];
	logic [FW-1:0] trace_cnt_d [CORES];

	logic          v_s1;
	logic [63:0]   tmp_s1;
	logic [CW-1:0] guess_s1;
	logic          miss_s1;
	logic          out_adv;
	logic          s1_adv;
	logic          m_valid_q;
	logic [OUT_W-1:0] result_q;
	logic [31:0]   guess_ext;

	assign rng_next = xorshift32(rng_q);

	generate
		if (POW2) begin : g_rng_mask
			assign rng_guess = rng_next[CW-1:0];
		end else begin : g_rng_mod
			// Residue by nibble weights 16^i mod CORES, folded twice, then reduced.
			logic [10:0] sum1;
			logic [9:0]  sum2;
			logic [9:0]  rem;
			always_comb begin
				int w;
				sum1 = '0;
				w = 1;
				for (int i = 0; i < 8; i++) begin
					sum1 = sum1 + 11'(rng_next[4*i +: 4] * 4'(w));
					w = (w * 16) % CORES;
				end
				sum2 = 10'(sum1[3:0]);
				w = 16 % CORES;
				sum2 = sum2 + 10'(sum1[7:4] * 4'(w));
				w = (w * 16) % CORES;
				sum2 = sum2 + 10'(sum1[10:8] * 4'(w));
				rem = sum2;
				for (int k = 7; k >= 0; k--) begin
					if (int'(rem) >= (CORES << k)) begin
						rem = rem - 10'(CORES << k);
					end
				end
				rng_guess = rem[CW-1:0];
			end
		end
	endgenerate

	// Shared arg-max tree; the left child holds the lower indices and wins ties.
	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			node_val[LEAVES-1+i] = '0;
			node_idx[LEAVES-1+i] = CW'(i);
		end
		for (int i = 0; i < CORES; i++) begin
			node_val[LEAVES-1+i] = (cfg.policy == POL_WINDOW) ? 32'(trace_cnt_q[i])
				: use_cnt_q[i];
		end
		for (int n = LEAVES - 2; n >= 0; n--) begin
			if (node_val[2*n+2] > node_val[2*n+1]) begin
				node_val[n] = node_val[2*n+2];
				node_idx[n] = node_idx[2*n+2];
			end else begin
				node_val[n] = node_val[2*n+1];
				node_idx[n] = node_idx[2*n+1];
			end
		end
	end

	always_comb begin
		case (cfg.policy)
			POL_RECENT: guess = last_valid_q ? last_core_q : q_core;
			POL_RANDOM: guess = rng_guess;
			POL_FREQ:   guess = node_idx[0];
			POL_WINDOW: guess = (fill_q == '0) ? q_core : node_idx[0];
			default:    guess = q_core;
		endcase
	end

	assign miss = guess != q_core;
	assign full = fill_q == FW'(WINDOW);
	assign push = q_pop && (cfg.policy == POL_WINDOW);

	always_comb begin
		if (!push) begin
			head_d = head_q;
		end else if (head_q == HW'(WINDOW - 1)) begin
			head_d = '0;
		end else begin
			head_d = head_q + 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < CORES; i++) begin
			use_cnt_d[i] = use_cnt_q[i];
			if ((q_core == CW'(i)) && (use_cnt_q[i] != '1)) begin
				use_cnt_d[i] = use_cnt_q[i] + 1'b1;
			end
			trace_cnt_d[i] = trace_cnt_q[i];
			if (full && (ring_old_q == CW'(i)) && (trace_cnt_q[i] != '0)) begin
				trace_cnt_d[i] = trace_cnt_d[i] - 1'b1;
			end
			if (q_core == CW'(i)) begin
				trace_cnt_d[i] = trace_cnt_d[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_core_q  <= '0;
			rng_q        <= RNG_RESET;
			head_q       <= '0;
			fill_q       <= '0;
			for (int i = 0; i < CORES; i++) begin
				use_cnt_q[i]   <= '0;
				trace_cnt_q[i] <= '0;
			end
		end else if (q_pop) begin
			case (cfg.policy)
				POL_RECENT: begin
					last_core_q  <= q_core;
					last_valid_q <= 1'b1;
				end
				POL_RANDOM: begin
					rng_q <= rng_next;
				end
				POL_FREQ: begin
					use_cnt_q <= use_cnt_d;
				end
				POL_WINDOW: begin
					trace_cnt_q <= trace_cnt_d;
					head_q      <= head_d;
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The entry at the next head is fetched ahead; a one-entry window bypasses the write.
	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[head_q] <= q_core;
		end
		if (push && (head_d == head_q)) begin
			ring_old_q <= q_core;
		end else begin
			ring_old_q <= ring_mem[head_d];
		end
	end

	assign out_adv = !m_valid_q || m_axis_tready;
	assign s1_adv  = !v_s1 || out_adv;
	assign q_pop   = q_valid && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= q_pop;
			end
			if (out_adv) begin
				m_valid_q <= v_s1;
			end
		end
	end

	assign guess_ext = 32'(guess_s1);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tmp_s1   <= q_tmp;
			guess_s1 <= guess;
			miss_s1  <= miss;
		end
		if (out_adv) begin
			result_q <= {5'b0, miss_s1, guess_ext[1:0],
				tmp_s1 + 64'(miss_s1 ? cfg.mispredict_penalty_ns : cfg.hit_overhead_ns)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = result_q;

endmodule

// ===== src/core_predictor_time_offset.sv =====
// ----------------------------------------------------------------------------
// core_predictor_time_offset
// Core predictor with a penalty-adjusted hardware-to-secure clock difference.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output is not stalled and
// delivers one result beat per input, in order. The rate is set by the
// prediction stage, which reads and updates the active policy's state
// (counters, ring buffer, random word) in a single cycle per item. A
// four-entry queue sits between the arithmetic front end and the prediction
// back end, and the input stalls only once that queue and the two front
// stages hold four items. Configuration registers should be written only
// while no item is in flight.
module core_predictor_time_offset import cpto_pkg::*; #(
	parameter int CORES  = 4,
	parameter int WINDOW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// phc_ns [63:0], secure_seconds [95:64], secure_millis [105:96],
	// core_id [137:106], zero fill [143:138]
	input  logic [IN_W-1:0]   s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// offset_ns [63:0], guessed_core [65:64], missed [66], zero fill [71:67]
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = $clog2(CORES);

	cfg_t               cfg_q;
	reg_idx_t           reg_idx;
	logic               q_push;
	logic [63:0]        q_push_tmp;
	logic [CW-1:0]      q_push_core;
	logic               q_pop;
	logic               q_valid;
	logic [63:0]        q_pop_tmp;
	logic [CW-1:0]      q_pop_core;
	logic [Q_LVL_W-1:0] q_level;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy                <= POL_RECENT;
			cfg_q.mispredict_penalty_ns <= MISPREDICT_RESET;
			cfg_q.hit_overhead_ns       <= HIT_RESET;
			cfg_q.passive_error_ns      <= PASSIVE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_POLICY:     cfg_q.policy                <= policy_t'(pwdata[1:0]);
				REG_MISPREDICT: cfg_q.mispredict_penalty_ns <= pwdata[23:0];
				REG_HIT:        cfg_q.hit_overhead_ns       <= pwdata[23:0];
				REG_PASSIVE:    cfg_q.passive_error_ns      <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_POLICY:     prdata = 32'(cfg_q.policy);
			REG_MISPREDICT: prdata = 32'(cfg_q.mispredict_penalty_ns);
			REG_HIT:        prdata = 32'(cfg_q.hit_overhead_ns);
			REG_PASSIVE:    prdata = 32'(cfg_q.passive_error_ns);
			default:        prdata = '0;
		endcase
	end

	cpto_front #(
		.CORES(CORES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_level      (q_level),
		.q_push       (q_push),
		.q_tmp        (q_push_tmp),
		.q_core       (q_push_core)
	);

	cpto_queue #(
		.CORES(CORES)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tmp (q_push_tmp),
		.push_core(q_push_core),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_tmp  (q_pop_tmp),
		.pop_core (q_pop_core),
		.level    (q_level)
	);

	cpto_back #(
		.CORES (CORES),
		.WINDOW(WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_tmp        (q_pop_tmp),
		.q_core       (q_pop_core),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= Q_LVL_W'(Q_DEPTH))
		else $error("Queue level exceeds its depth.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_level != '0))
		else $error("Queue popped while empty.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> ((q_level < Q_LVL_W'(Q_DEPTH)) || q_pop))
		else $error("Queue pushed while full.");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the core predictor and clock offset block. Input
// beats are fed through the slave stream and every accepted beat is run
// through a local predictor that keeps its own copy of the prediction state
// and the register file. Result beats are compared field by field, in order,
// with the predicted results. The registers are written and read back over
// the APB port while nothing is in flight. Both stream sides idle at random,
// with one long stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cpto_pkg::*;

	localparam int NCORES      = 4;
	localparam int WIN         = 32;
	localparam int DRAIN       = 12;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [63:0] diff;
		logic [1:0]  core;
		logic        missed;
	} offset_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	offset_result_t pending_results[$];
	int             mismatch_count = 0;
	int             cycle_count = 0;
	logic           calm = 1'b0;
	logic [1:0]     favourite_core = 2'd0;

	policy_t     cur_policy = POL_RECENT;
	logic [23:0] cur_miss_pen = MISPREDICT_RESET;
	logic [23:0] cur_hit_pen = HIT_RESET;
	logic [23:0] cur_passive = PASSIVE_RESET;

	logic [1:0]  recent_core = 2'd0;
	logic        recent_valid = 1'b0;
	logic [31:0] rng_state = RNG_RESET;
	logic [31:0] use_count [NCORES] = '{default: '0};
	logic [1:0]  trace_ring [WIN];
	logic [4:0]  trace_head = '0;
	logic [5:0]  trace_fill = '0;
	logic [5:0]  trace_count [NCORES] = '{default: '0};

	core_predictor_time_offset #(
		.CORES(NCORES),
		.WINDOW(WIN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic offset_result_t predict_offset(input logic [63:0] phc,
			input logic [31:0] secs, input logic [9:0] millis, input logic [31:0] core_raw);
		offset_result_t r;
		logic [1:0]  actual;
		logic [1:0]  guess;
		logic [1:0]  oldest;
		logic [63:0] trusted_ns;
		logic [63:0] adj_ns;
		int          i;
		if (core_raw[31])
			actual = 2'd0;
		else if (core_raw >= NCORES)
			actual = 2'(NCORES - 1);
		else
			actual = core_raw[1:0];
		case (cur_policy)
		POL_RECENT: begin
			guess = recent_valid ? recent_core : actual;
			recent_core = actual;
			recent_valid = 1'b1;
		end
		POL_RANDOM: begin
			rng_state = rng_state ^ (rng_state << 13);
			rng_state = rng_state ^ (rng_state >> 17);
			rng_state = rng_state ^ (rng_state << 5);
			guess = rng_state[1:0];
		end
		POL_FREQ: begin
			guess = 2'd0;
			for (i = 1; i < NCORES; i++)
				if (use_count[i] > use_count[guess])
					guess = 2'(i);
			if (use_count[actual] != 32'hFFFF_FFFF)
				use_count[actual] = use_count[actual] + 32'd1;
		end
		default: begin
			guess = actual;
			if (trace_fill != 0) begin
				guess = 2'd0;
				for (i = 1; i < NCORES; i++)
					if (trace_count[i] > trace_count[guess])
						guess = 2'(i);
			end
			if (trace_fill >= WIN) begin
				oldest = trace_ring[trace_head];
				if (trace_count[oldest] > 0)
					trace_count[oldest] = trace_count[oldest] - 6'd1;
			end
			trace_ring[trace_head] = actual;
			trace_count[actual] = trace_count[actual] + 6'd1;
			trace_head = trace_head + 5'd1;
			if (trace_fill < WIN)
				trace_fill = trace_fill + 6'd1;
		end
		endcase
		r.core = guess;
		r.missed = (guess != actual);
		trusted_ns = {32'b0, secs} * 64'd1000000000 + {54'b0, millis} * 64'd1000000;
		adj_ns = trusted_ns - {40'b0, r.missed ? cur_miss_pen : cur_hit_pen};
		r.diff = phc - adj_ns - {40'b0, cur_passive};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : scoreboard
		offset_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected", m_axis_tdata[63:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[63:0] !== want.diff)
					report_mismatch("offset_ns", m_axis_tdata[63:0], want.diff);
				if (m_axis_tdata[65:64] !== want.core)
					report_mismatch("guessed_core", 64'(m_axis_tdata[65:64]), 64'(want.core));
				if (m_axis_tdata[66] !== want.missed)
					report_mismatch("missed", 64'(m_axis_tdata[66]), 64'(want.missed));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			pending_results.push_back(predict_offset(s_axis_tdata[63:0], s_axis_tdata[95:64],
				s_axis_tdata[105:96], s_axis_tdata[137:106]));
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input reg_idx_t idx, input logic [31:0] want);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			report_mismatch($sformatf("register %s read back", idx.name()), 64'(got), 64'(want));
	endtask

	task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
		apb_write(idx, value);
		case (idx)
		REG_POLICY:     cur_policy = policy_t'(value[1:0]);
		REG_MISPREDICT: cur_miss_pen = value[23:0];
		REG_HIT:        cur_hit_pen = value[23:0];
		default:        cur_passive = value[23:0];
		endcase
		check_register(idx, idx == REG_POLICY ? {30'b0, value[1:0]} : {8'b0, value[23:0]});
	endtask

	task automatic send_sample(input logic [63:0] phc, input logic [31:0] secs,
			input logic [9:0] millis, input logic [31:0] core_id);
		while (!calm && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, core_id, millis, secs, phc};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		// Waiting on the clock lets the scoreboard log the last accepted beat first.
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		hold_until_drained();
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [31:0] random_core_id();
		case ($urandom_range(9))
		0:       return $urandom;
		1:       return 32'h8000_0000 | $urandom;
		2:       return $urandom_range(32'h7FFF_FFFF, NCORES);
		3, 4, 5: return {30'b0, favourite_core};
		default: return $urandom_range(NCORES - 1);
		endcase
	endfunction

	task automatic send_random_sample();
		logic [63:0] phc;
		logic [31:0] secs;
		logic [9:0]  millis;
		case ($urandom_range(15))
		0:       phc = 64'h8000_0000_0000_0000;
		1:       phc = 64'h7FFF_FFFF_FFFF_FFFF;
		default: phc = {$urandom, $urandom};
		endcase
		case ($urandom_range(15))
		0:       secs = 32'h0;
		1:       secs = 32'hFFFF_FFFF;
		default: secs = $urandom;
		endcase
		millis = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1000))
			: 10'($urandom_range(999));
		if ($urandom_range(31) == 0)
			favourite_core = 2'($urandom_range(NCORES - 1));
		send_sample(phc, secs, millis, random_core_id());
	endtask

	task automatic test_register_reset();
		check_register(REG_POLICY, {30'b0, POL_RECENT});
		check_register(REG_MISPREDICT, {8'b0, MISPREDICT_RESET});
		check_register(REG_HIT, {8'b0, HIT_RESET});
		check_register(REG_PASSIVE, {8'b0, PASSIVE_RESET});
	endtask

	task automatic test_recent_policy();
		send_sample(64'h0, 32'h0, 10'd0, 32'd2);
		send_sample(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 10'd999, 32'd2);
		send_sample(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF);
		send_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 10'd1000, 32'h8000_0000);
		send_sample(64'h1234_5678_9ABC_DEF0, 32'd1, 10'd1, 32'h7FFF_FFFF);
		send_sample(64'h0, 32'h5555_5555, 10'h2AA, 32'd4);
		send_sample(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 10'h155, 32'd3);
		send_sample(64'h5555_5555_5555_5555, 32'd7, 10'd500, 32'd1);
	endtask

	task automatic test_random_policy();
		int c;
		wait_drained();
		set_register(REG_POLICY, {30'b0, POL_RANDOM});
		for (c = 0; c < NCORES; c++)
			send_sample({$urandom, $urandom}, $urandom, 10'($urandom_range(999)), c);
	endtask

	task automatic test_frequency_policy();
		wait_drained();
		set_register(REG_POLICY, {30'b0, POL_FREQ});
		// Counts start at zero, so the first guess is core zero; the later
		// beats build a tie between cores one and two.
		send_sample(64'd1000, 32'd1, 10'd0, 32'd1);
		send_sample(64'd2000, 32'd1, 10'd0, 32'd2);
		send_sample(64'd3000, 32'd1, 10'd0, 32'd2);
		send_sample(64'd4000, 32'd1, 10'd0, 32'd1);
		send_sample(64'd5000, 32'd1, 10'd0, 32'hFFFF_FFF0);
	endtask

	task automatic test_window_policy();
		wait_drained();
		set_register(REG_POLICY, {30'b0, POL_WINDOW});
		// The first beat of the window policy finds the window empty.
		send_sample(64'd10, 32'd2, 10'd3, 32'd3);
		send_sample(64'd20, 32'd2, 10'd3, 32'd1);
		send_sample(64'd30, 32'd2, 10'd3, 32'd1);
		send_sample(64'd40, 32'd2, 10'd3, 32'd5);
		send_sample(64'd50, 32'd2, 10'd3, 32'hFFFF_FFF9);
	endtask

	task automatic test_random_phases();
		int p;
		int n;
		for (p = 0; p < 10; p++) begin
			wait_drained();
			set_register(REG_POLICY, 32'(p % 4) | ($urandom & 32'hFFFF_FFFC));
			case (p)
			0: begin
				set_register(REG_MISPREDICT, 32'h0);
				set_register(REG_HIT, 32'h0);
				set_register(REG_PASSIVE, 32'h0);
			end
			1: begin
				set_register(REG_MISPREDICT, 32'hFFFF_FFFF);
				set_register(REG_HIT, 32'hFFFF_FFFF);
				set_register(REG_PASSIVE, 32'hFFFF_FFFF);
			end
			2: begin
				set_register(REG_MISPREDICT, 32'h00FF_FFFF);
				set_register(REG_HIT, 32'h0);
				set_register(REG_PASSIVE, $urandom);
			end
			default: begin
				set_register(REG_MISPREDICT, $urandom);
				set_register(REG_HIT, $urandom);
				set_register(REG_PASSIVE, $urandom);
			end
			endcase
			for (n = 0; n < 140; n++)
				send_random_sample();
		end
	endtask

	task automatic test_no_idle_stretch();
		int n;
		wait_drained();
		set_register(REG_POLICY, {30'b0, POL_WINDOW});
		calm = 1'b1;
		for (n = 0; n < 250; n++)
			send_random_sample();
		calm = 1'b0;
	endtask

	task automatic test_drain_pressure();
		int n;
		wait_drained();
		set_register(REG_POLICY, {30'b0, POL_FREQ});
		for (n = 0; n < 100; n++) begin
			send_random_sample();
			if (n % 5 == 4)
				hold_until_drained();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_register_reset();
		test_recent_policy();
		test_random_policy();
		test_frequency_policy();
		test_window_policy();
		test_random_phases();
		test_no_idle_stretch();
		test_drain_pressure();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
